// ----- rtl/core/iheapq_pkg.sv -----
// Shared codes and field widths for the indexed binary heap queue.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none
package iheapq_pkg;
    localparam int MODE_W   = 3;
    localparam int HANDLE_W = 6;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPRIO  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd4;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_TAKE  = 7'b0001000,
        S_UP    = 7'b0010000,
        S_DOWN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/core/indexed_binary_heap_queue.sv -----
// Indexed binary max-heap queue with its heap memory, slot table and sequencer; uses iheapq_pkg.
// Each accepted beat is looked up first; peek and rejected beats finish there. Pop and remove then
// take the entry out; when it was the last entry the beat finishes, else the moved entry sifts up
// and, if it did not rise, sifts down. Insert and reprioritise go to the sift up, then the sift down.
// One beat is handled at a time: o_in_stall stays high until the sequencer is back in idle.
// Reset: synchronous; a clearing pass fills the slot table before any input is taken.
`default_nettype none
module indexed_binary_heap_queue #(
    parameter int CAPACITY       = 64,
    parameter int HANDLE_COUNT   = 64,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [iheapq_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [iheapq_pkg::HANDLE_W-1:0]     i_item_handle,
    input  wire logic [iheapq_pkg::PRIO_W-1:0]       i_item_priority,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [iheapq_pkg::STATUS_W-1:0]          o_status,
    output logic [iheapq_pkg::HANDLE_W-1:0]          o_out_handle,
    output logic [iheapq_pkg::PRIO_W-1:0]            o_out_priority,
    output logic [iheapq_pkg::OCC_W-1:0]             o_occupancy
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
    localparam int PW = PRIORITY_WIDTH;
    localparam int LW = AW + 2;

    typedef struct packed {
        logic [PW-1:0] p;
        logic [HW-1:0] h;
    } t_entry;

    t_entry          heap_mem [CAPACITY];
    logic [CW-1:0]   slot_mem [HANDLE_COUNT];

    iheapq_pkg::t_state r_state, n_state;
    logic [iheapq_pkg::MODE_W-1:0]   r_mode;
    logic [iheapq_pkg::HANDLE_W-1:0] r_hdl;
    logic [PW-1:0]                   r_pri;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_pos, n_pos;
    t_entry          r_e, n_e;
    logic            r_moved, n_moved;
    logic [iheapq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [HW-1:0]   r_oh, n_oh;
    logic [PW-1:0]   r_op, n_op;
    logic [HW-1:0]   r_clr;
    logic            r_ov;
    logic [iheapq_pkg::STATUS_W-1:0] r_o_status;
    logic [HW-1:0]   r_o_oh;
    logic [PW-1:0]   r_o_op;
    logic [CW-1:0]   r_o_occ;

    t_entry          r_rd_a, r_rd_b;
    logic [CW-1:0]   r_rd_slot;

    logic            hw_en;
    logic [AW-1:0]   hw_addr;
    t_entry          hw_data;
    logic [AW-1:0]   ra_addr, rb_addr;
    logic            sw_en;
    logic [HW-1:0]   sw_addr;
    logic [CW-1:0]   sw_data;
    logic [HW-1:0]   sr_addr;

    logic            in_acc, out_acc, out_free;
    logic            h_ok, queued;
    logic [HW-1:0]   h_idx;
    logic [CW-1:0]   last;
    logic [LW-1:0]   left, right;
    t_entry          pick;
    logic [LW-1:0]   pick_idx;

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        parent_of = (p - AW'(1)) >> 1;
    endfunction

    function automatic logic [AW-1:0] clamp(input logic [LW-1:0] idx);
        clamp = (idx < LW'(CAPACITY)) ? idx[AW-1:0] : '0;
    endfunction

    assign in_acc   = i_in_valid && (r_state == iheapq_pkg::S_IDLE);
    assign out_acc  = r_ov && !i_out_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != iheapq_pkg::S_IDLE);

    assign h_ok   = (32'(r_hdl) < HANDLE_COUNT);
    assign h_idx  = h_ok ? HW'(r_hdl) : '0;
    assign queued = h_ok && (r_rd_slot < r_cnt);
    assign last   = r_cnt - CW'(1);
    assign left   = {1'b0, r_pos, 1'b1};
    assign right  = left + LW'(1);

    always_comb begin
        if ((right < LW'(r_cnt)) && !(r_rd_a.p > r_rd_b.p)) begin
            pick     = r_rd_b;
            pick_idx = right;
        end else begin
            pick     = r_rd_a;
            pick_idx = left;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_e      = r_e;
        n_moved  = r_moved;
        n_status = r_status;
        n_oh     = r_oh;
        n_op     = r_op;
        hw_en    = 1'b0;
        hw_addr  = r_pos;
        hw_data  = r_e;
        ra_addr  = '0;
        rb_addr  = '0;
        sw_en    = 1'b0;
        sw_addr  = r_e.h;
        sw_data  = CW'(r_pos);
        sr_addr  = (32'(i_item_handle) < HANDLE_COUNT) ? HW'(i_item_handle) : '0;
        unique case (r_state)
            iheapq_pkg::S_CLEAR: begin
                sw_en   = 1'b1;
                sw_addr = r_clr;
                sw_data = CW'(CAPACITY);
                if (r_clr == HW'(HANDLE_COUNT - 1)) begin
                    n_state = iheapq_pkg::S_IDLE;
                end
            end
            iheapq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = iheapq_pkg::S_LOOK;
                end
            end
            iheapq_pkg::S_LOOK: begin
                n_status = iheapq_pkg::ST_OK;
                n_oh     = '0;
                n_op     = '0;
                n_moved  = 1'b0;
                n_state  = iheapq_pkg::S_DONE;
                unique case (r_mode)
                    iheapq_pkg::MODE_INSERT: begin
                        if (!h_ok) begin
                            n_status = iheapq_pkg::ST_NOT_QUEUED;
                        end else if (queued) begin
                            n_status = iheapq_pkg::ST_DUPLICATE;
                        end else if (r_cnt == CW'(CAPACITY)) begin
                            n_status = iheapq_pkg::ST_FULL;
                        end else begin
                            n_e     = '{p: r_pri, h: h_idx};
                            n_pos   = r_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            ra_addr = parent_of(r_cnt[AW-1:0]);
                            n_state = iheapq_pkg::S_UP;
                        end
                    end
                    iheapq_pkg::MODE_POP: begin
                        if (r_cnt == '0) begin
                            n_status = iheapq_pkg::ST_EMPTY;
                        end else begin
                            sw_en   = 1'b1;
                            sw_addr = r_rd_a.h;
                            sw_data = CW'(CAPACITY);
                            n_pos   = '0;
                            n_cnt   = last;
                            ra_addr = '0;
                            rb_addr = last[AW-1:0];
                            n_state = iheapq_pkg::S_TAKE;
                        end
                    end
                    iheapq_pkg::MODE_REMOVE: begin
                        if (!queued) begin
                            n_status = iheapq_pkg::ST_NOT_QUEUED;
                        end else begin
                            sw_en   = 1'b1;
                            sw_addr = h_idx;
                            sw_data = CW'(CAPACITY);
                            n_pos   = r_rd_slot[AW-1:0];
                            n_cnt   = last;
                            ra_addr = r_rd_slot[AW-1:0];
                            rb_addr = last[AW-1:0];
                            n_state = iheapq_pkg::S_TAKE;
                        end
                    end
                    iheapq_pkg::MODE_REPRIO: begin
                        if (!queued) begin
                            n_status = iheapq_pkg::ST_NOT_QUEUED;
                        end else begin
                            n_e     = '{p: r_pri, h: h_idx};
                            n_pos   = r_rd_slot[AW-1:0];
                            ra_addr = parent_of(r_rd_slot[AW-1:0]);
                            n_state = iheapq_pkg::S_UP;
                        end
                    end
                    iheapq_pkg::MODE_PEEK: begin
                        if (r_cnt == '0) begin
                            n_status = iheapq_pkg::ST_EMPTY;
                        end else begin
                            n_oh = r_rd_a.h;
                            n_op = r_rd_a.p;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            iheapq_pkg::S_TAKE: begin
                n_oh = r_rd_a.h;
                n_op = r_rd_a.p;
                if (CW'(r_pos) < r_cnt) begin
                    n_e     = r_rd_b;
                    ra_addr = parent_of(r_pos);
                    n_state = iheapq_pkg::S_UP;
                end else begin
                    n_state = iheapq_pkg::S_DONE;
                end
            end
            iheapq_pkg::S_UP: begin
                if ((r_pos != '0) && (r_e.p > r_rd_a.p)) begin
                    hw_en   = 1'b1;
                    hw_data = r_rd_a;
                    sw_en   = 1'b1;
                    sw_addr = r_rd_a.h;
                    n_pos   = parent_of(r_pos);
                    n_moved = 1'b1;
                    ra_addr = parent_of(parent_of(r_pos));
                end else if (r_moved) begin
                    hw_en   = 1'b1;
                    sw_en   = 1'b1;
                    n_state = iheapq_pkg::S_DONE;
                end else begin
                    ra_addr = clamp(left);
                    rb_addr = clamp(right);
                    n_state = iheapq_pkg::S_DOWN;
                end
            end
            iheapq_pkg::S_DOWN: begin
                if ((left < LW'(r_cnt)) && (r_e.p < pick.p)) begin
                    hw_en   = 1'b1;
                    hw_data = pick;
                    sw_en   = 1'b1;
                    sw_addr = pick.h;
                    n_pos   = pick_idx[AW-1:0];
                    ra_addr = clamp({pick_idx[LW-2:0], 1'b1});
                    rb_addr = clamp({pick_idx[LW-2:0], 1'b1} + LW'(1));
                end else begin
                    hw_en   = 1'b1;
                    sw_en   = 1'b1;
                    n_state = iheapq_pkg::S_DONE;
                end
            end
            iheapq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = iheapq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iheapq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            heap_mem[hw_addr] <= hw_data;
        end
        r_rd_a <= heap_mem[ra_addr];
        r_rd_b <= heap_mem[rb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            slot_mem[sw_addr] <= sw_data;
        end
        r_rd_slot <= slot_mem[sr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iheapq_pkg::S_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == iheapq_pkg::S_CLEAR) begin
                r_clr <= r_clr + HW'(1);
            end
            if ((r_state == iheapq_pkg::S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_hdl  <= i_item_handle;
            r_pri  <= PW'(i_item_priority);
        end
        r_pos    <= n_pos;
        r_e      <= n_e;
        r_moved  <= n_moved;
        r_status <= n_status;
        r_oh     <= n_oh;
        r_op     <= n_op;
        if ((r_state == iheapq_pkg::S_DONE) && out_free) begin
            r_o_status <= r_status;
            r_o_oh     <= r_oh;
            r_o_op     <= r_op;
            r_o_occ    <= r_cnt;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_out_handle   = iheapq_pkg::HANDLE_W'(r_o_oh);
    assign o_out_priority = iheapq_pkg::PRIO_W'(r_o_op);
    assign o_occupancy    = iheapq_pkg::OCC_W'(r_o_occ);
endmodule
`default_nettype wire

// ----- rtl/core/iheapq_chk.sv -----
// Port checker for the indexed binary heap queue, bound to the top level.
// Depends on iheapq_pkg.
`default_nettype none
module iheapq_chk #(
    parameter int CAPACITY = 64
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [iheapq_pkg::STATUS_W-1:0] o_status,
    input wire logic [iheapq_pkg::HANDLE_W-1:0] o_out_handle,
    input wire logic [iheapq_pkg::PRIO_W-1:0]   o_out_priority,
    input wire logic [iheapq_pkg::OCC_W-1:0]    o_occupancy
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_out_handle) && $stable(o_out_priority) && $stable(o_occupancy))
        else $error("Stalled result beat changed.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == iheapq_pkg::ST_EMPTY) |->
            (o_out_handle == '0) && (o_out_priority == '0) && (o_occupancy == '0))
        else $error("Empty result carries data or a nonzero occupancy.");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == iheapq_pkg::ST_FULL) |->
            (32'(o_occupancy) == CAPACITY))
        else $error("Full status with spare room.");

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_occupancy) <= CAPACITY))
        else $error("Occupancy above capacity.");
endmodule

bind indexed_binary_heap_queue iheapq_chk #(.CAPACITY(CAPACITY)) u_iheapq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_out_handle   (o_out_handle),
    .o_out_priority (o_out_priority),
    .o_occupancy    (o_occupancy)
);
`default_nettype wire
